>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define QBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define QBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/qbd_pkg.sv
// Shared types, codes and helpers of the quantized block dequantizer.
// No dependencies.
package qbd_pkg;

    localparam logic [1:0] FMT_Q4K = 2'd0;
    localparam logic [1:0] FMT_Q5  = 2'd1;
    localparam logic [1:0] FMT_Q8  = 2'd2;

    localparam logic [7:0] SIZE_Q4K = 8'd144;
    localparam logic [7:0] SIZE_Q5  = 8'd22;
    localparam logic [7:0] SIZE_Q8  = 8'd34;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    // What the latched word asks the sequencer to do
    typedef enum logic [1:0] {K_NONE, K_Q4K, K_Q5, K_Q8} t_kind;

    // Operand selection of the arithmetic unit
    typedef enum logic [2:0] {OP_DSC, OP_MMIN, OP_PROD, OP_DIFF, OP_Q5, OP_Q8} t_opsel;

    // Destination of an arithmetic result
    typedef enum logic [1:0] {WB_NONE, WB_T1, WB_T2, WB_OUT} t_wb;

    typedef struct packed {
        logic   accept;
        t_opsel opsel;
        t_wb    wb;
        logic   half;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_busy;
    } t_status;

    // Exact conversion of a small signed integer to binary32
    function automatic logic [31:0] int_to_single(input logic signed [8:0] v);
        logic        s;
        logic [7:0]  mag;
        logic [2:0]  pos;
        logic [23:0] sh;
        s   = v[8];
        mag = s ? 8'(-v) : v[7:0];
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) pos = 3'(i);
        end
        sh = {16'b0, mag} << (5'd23 - {2'b0, pos});
        if (mag == 8'd0) return 32'd0;
        return {s, 8'(8'd127 + {5'b0, pos}), sh[22:0]};
    endfunction

endpackage

>>> sv/qbd_fpu.sv
// Two-step binary32 multiply / subtract unit, round to nearest even.
// Depends on qbd_pkg. Step-one results registered, step two combinational after them.
module qbd_fpu (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_res
);
    logic        r_spec, n_spec;
    logic [31:0] r_sval, n_sval;
    logic        r_sign, n_sign;
    logic [9:0]  r_exp, n_exp;
    logic [27:0] r_sum, n_sum;

    logic        sa, sb, sy;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [47:0] prod;
    logic        swap, s_l, s_s;
    logic [7:0]  e_l, e_s, d;
    logic [22:0] f_l, f_s;
    logic [27:0] m_l, m_s, m_sh, m_mask, m_ss;

    assign sa = i_a[31];
    assign sb = i_b[31];
    assign sy = ~sb;
    assign ea = i_a[30:23];
    assign eb = i_b[30:23];
    assign fa = i_a[22:0];
    assign fb = i_b[22:0];
    assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    assign a_zero = (ea == 8'd0);
    assign b_zero = (eb == 8'd0);
    assign prod   = {1'b1, fa} * {1'b1, fb};

    // Step one: special cases, product or aligned add
    always_comb begin
        swap   = {eb, fb} > {ea, fa};
        s_l    = swap ? sy : sa;
        s_s    = swap ? sa : sy;
        e_l    = swap ? eb : ea;
        e_s    = swap ? ea : eb;
        f_l    = swap ? fb : fa;
        f_s    = swap ? fa : fb;
        d      = e_l - e_s;
        m_l    = {2'b01, f_l, 3'b000};
        m_s    = {2'b01, f_s, 3'b000};
        m_sh   = m_s >> d[4:0];
        m_mask = (28'd1 << d[4:0]) - 28'd1;
        if (d >= 8'd27) begin
            m_ss = 28'd1;
        end else begin
            m_ss = {m_sh[27:1], m_sh[0] | (|(m_s & m_mask))};
        end
        n_spec = 1'b1;
        n_sval = 32'd0;
        n_sign = 1'b0;
        n_exp  = 10'd0;
        n_sum  = 28'd0;
        if (!i_sub) begin
            n_sign = sa ^ sb;
            if (a_nan) begin
                n_sval = i_a | qbd_pkg::QUIET_BIT;
            end else if (b_nan) begin
                n_sval = i_b | qbd_pkg::QUIET_BIT;
            end else if (a_inf) begin
                n_sval = b_zero ? qbd_pkg::DEFAULT_NAN : {sa ^ sb, 8'hFF, 23'd0};
            end else if (b_inf) begin
                n_sval = a_zero ? qbd_pkg::DEFAULT_NAN : {sa ^ sb, 8'hFF, 23'd0};
            end else if (a_zero || b_zero) begin
                n_sval = {sa ^ sb, 31'd0};
            end else begin
                n_spec = 1'b0;
                n_exp  = {2'b0, ea} + {2'b0, eb} - 10'd127;
                n_sum  = {prod[47:21], |prod[20:0]};
            end
        end else begin
            if (a_nan) begin
                n_sval = i_a | qbd_pkg::QUIET_BIT;
            end else if (b_nan) begin
                n_sval = i_b | qbd_pkg::QUIET_BIT;
            end else if (a_inf) begin
                n_sval = (b_inf && (sa != sy)) ? qbd_pkg::DEFAULT_NAN : i_a;
            end else if (b_inf) begin
                n_sval = {sy, i_b[30:0]};
            end else if (a_zero && b_zero) begin
                n_sval = {sa & sy, 31'd0};
            end else if (a_zero) begin
                n_sval = {sy, i_b[30:0]};
            end else if (b_zero) begin
                n_sval = i_a;
            end else begin
                n_spec = 1'b0;
                n_sign = s_l;
                n_exp  = {2'b0, e_l};
                n_sum  = (s_l == s_s) ? (m_l + m_ss) : (m_l - m_ss);
            end
        end
    end

    // Hold step-one results
    always_ff @(posedge i_clk) begin
        r_spec <= n_spec;
        r_sval <= n_sval;
        r_sign <= n_sign;
        r_exp  <= n_exp;
        r_sum  <= n_sum;
    end

    logic [4:0]  lz;
    logic [26:0] m27;
    logic [9:0]  e_n;
    logic        up;
    logic [30:0] mag;

    // Step two: normalize and round
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r_sum[i]) lz = 5'(26 - i);
        end
        if (r_sum[27]) begin
            m27 = {r_sum[27:2], r_sum[1] | r_sum[0]};
            e_n = r_exp + 10'd1;
        end else begin
            m27 = r_sum[26:0] << lz;
            e_n = r_exp - {5'b0, lz};
        end
        up  = m27[2] & (m27[1] | m27[0] | m27[3]);
        mag = {e_n[7:0], m27[25:3]} + {30'd0, up};
        if (r_spec) begin
            o_res = r_sval;
        end else if (r_sum == 28'd0) begin
            o_res = 32'd0;
        end else begin
            o_res = {r_sign, mag};
        end
    end

endmodule

>>> sv/qbd_datapath.sv
// Datapath: block position, header registers, scale tables, operands, result word.
// Depends on qbd_pkg and qbd_fpu.
module qbd_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    input  logic [7:0]       i_packed_byte,
    input  qbd_pkg::t_cmd    i_cmd,
    output qbd_pkg::t_status o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [31:0]      o_value_bits,
    output logic [7:0]       o_element_index,
    output logic             o_block_last,
    output logic             o_run_last
);
    logic [1:0]  r_fmt;
    logic [7:0]  r_pos;
    logic [7:0]  r_hlow;
    logic [31:0] r_main, r_min, r_mask;
    logic [5:0]  r_sc [8];
    logic [5:0]  r_mn [8];
    logic [7:0]  r_byte, r_p;
    logic        r_last;
    qbd_pkg::t_kind r_kind;
    logic [31:0] r_t1, r_t2;
    logic        r_ov;
    logic [31:0] r_val;
    logic [7:0]  r_idx;
    logic        r_blast, r_rlast;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] f;
        logic [3:0] pos;
        logic [3:0] sh;
        logic [9:0] fs;
        s   = h[15];
        e   = h[14:10];
        f   = h[9:0];
        pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (f[i]) pos = 4'(i);
        end
        sh = 4'd10 - pos;
        fs = f << sh;
        if (e == 5'd0) begin
            if (f == 10'd0) return {s, 31'd0};
            return {s, 8'(8'd113 - {4'b0, sh}), fs, 13'd0};
        end
        if (e == 5'd31) return {s, 8'hFF, f, 13'd0};
        return {s, 8'({3'b0, e} + 8'd112), f, 13'd0};
    endfunction

    // Position of the incoming word within its block
    logic [7:0] size, p_in;
    logic       fmt_ok, last_in;
    logic [3:0] sidx;
    always_comb begin
        fmt_ok = 1'b1;
        unique case (r_fmt)
            qbd_pkg::FMT_Q4K: size = qbd_pkg::SIZE_Q4K;
            qbd_pkg::FMT_Q5:  size = qbd_pkg::SIZE_Q5;
            qbd_pkg::FMT_Q8:  size = qbd_pkg::SIZE_Q8;
            default: begin
                size   = qbd_pkg::SIZE_Q8;
                fmt_ok = 1'b0;
            end
        endcase
        p_in    = (r_pos >= size) ? 8'd0 : r_pos;
        last_in = (p_in == size - 8'd1);
        sidx    = 4'(p_in - 8'd4);
    end

    // Latch header fields, advance position, take configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= qbd_pkg::FMT_Q4K;
            r_pos  <= 8'd0;
            r_hlow <= 8'd0;
            r_main <= 32'd0;
            r_min  <= 32'd0;
            r_mask <= 32'd0;
            r_kind <= qbd_pkg::K_NONE;
        end else begin
            if (i_cmd.accept) begin
                r_kind <= qbd_pkg::K_NONE;
                if (!fmt_ok) begin
                    r_pos <= 8'd0;
                end else begin
                    r_pos <= last_in ? 8'd0 : p_in + 8'd1;
                    if (p_in == 8'd0) begin
                        r_hlow <= i_packed_byte;
                    end else if (p_in == 8'd1) begin
                        r_main <= half_to_single({i_packed_byte, r_hlow});
                    end else if (r_fmt == qbd_pkg::FMT_Q4K) begin
                        if (p_in == 8'd2) begin
                            r_hlow <= i_packed_byte;
                        end else if (p_in == 8'd3) begin
                            r_min <= half_to_single({i_packed_byte, r_hlow});
                        end else if (p_in >= 8'd16) begin
                            r_kind <= qbd_pkg::K_Q4K;
                        end
                    end else if (r_fmt == qbd_pkg::FMT_Q5) begin
                        if (p_in < 8'd6) begin
                            case (p_in[2:0])
                                3'd2:    r_mask[7:0]   <= i_packed_byte;
                                3'd3:    r_mask[15:8]  <= i_packed_byte;
                                3'd4:    r_mask[23:16] <= i_packed_byte;
                                default: r_mask[31:24] <= i_packed_byte;
                            endcase
                        end else begin
                            r_kind <= qbd_pkg::K_Q5;
                        end
                    end else begin
                        r_kind <= qbd_pkg::K_Q8;
                    end
                end
            end
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
                r_pos <= 8'd0;
            end
        end
    end

    // Unpack the twelve scale bytes into six-bit scale and min pairs
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && fmt_ok && (r_fmt == qbd_pkg::FMT_Q4K)
            && (p_in >= 8'd4) && (p_in < 8'd16)) begin
            for (int i = 0; i < 4; i++) begin
                if (sidx == 4'(i)) begin
                    r_sc[i]           <= i_packed_byte[5:0];
                    r_sc[i + 4][5:4]  <= i_packed_byte[7:6];
                end
                if (sidx == 4'(i + 4)) begin
                    r_mn[i]           <= i_packed_byte[5:0];
                    r_mn[i + 4][5:4]  <= i_packed_byte[7:6];
                end
                if (sidx == 4'(i + 8)) begin
                    r_sc[i + 4][3:0]  <= i_packed_byte[3:0];
                    r_mn[i + 4][3:0]  <= i_packed_byte[7:4];
                end
            end
        end
    end

    // Hold the accepted word and its position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_packed_byte;
            r_p    <= p_in;
            r_last <= last_in;
        end
    end

    // Operand selection
    logic [7:0]  k8;
    logic [2:0]  j;
    logic [3:0]  nib, i5;
    logic        hb;
    logic [31:0] op_a, op_b, fres;
    logic        op_sub;
    always_comb begin
        k8   = r_p - 8'd16;
        j    = {k8[6:5], i_cmd.half};
        nib  = i_cmd.half ? r_byte[7:4] : r_byte[3:0];
        i5   = 4'(r_p - 8'd6);
        hb   = i_cmd.half ? r_mask[{1'b1, i5}] : r_mask[{1'b0, i5}];
        op_sub = 1'b0;
        case (i_cmd.opsel)
            qbd_pkg::OP_DSC: begin
                op_a = r_main;
                op_b = qbd_pkg::int_to_single({3'b0, r_sc[j]});
            end
            qbd_pkg::OP_MMIN: begin
                op_a = r_min;
                op_b = qbd_pkg::int_to_single({3'b0, r_mn[j]});
            end
            qbd_pkg::OP_PROD: begin
                op_a = r_t1;
                op_b = qbd_pkg::int_to_single({5'b0, nib});
            end
            qbd_pkg::OP_DIFF: begin
                op_a   = r_t1;
                op_b   = r_t2;
                op_sub = 1'b1;
            end
            qbd_pkg::OP_Q5: begin
                op_a = r_main;
                op_b = qbd_pkg::int_to_single({{4{~hb}}, ~hb, nib});
            end
            default: begin
                op_a = r_main;
                op_b = qbd_pkg::int_to_single({r_byte[7], r_byte});
            end
        endcase
    end

    qbd_fpu u_fpu (
        .i_clk (i_clk),
        .i_a   (op_a),
        .i_b   (op_b),
        .i_sub (op_sub),
        .o_res (fres)
    );

    // Element index and run flag of the word in flight
    logic [7:0] idx;
    logic       rlast;
    always_comb begin
        case (r_kind)
            qbd_pkg::K_Q4K: idx = {k8[6:5], i_cmd.half, k8[4:0]};
            qbd_pkg::K_Q5:  idx = {3'b0, i_cmd.half, i5};
            default:        idx = r_p - 8'd2;
        endcase
        rlast = (r_kind == qbd_pkg::K_Q8) ? 1'b1 : i_cmd.half;
    end

    // Write back arithmetic results
    always_ff @(posedge i_clk) begin
        case (i_cmd.wb)
            qbd_pkg::WB_T1: r_t1 <= fres;
            qbd_pkg::WB_T2: r_t2 <= fres;
            qbd_pkg::WB_OUT: begin
                r_val   <= fres;
                r_idx   <= idx;
                r_blast <= r_last;
                r_rlast <= rlast;
            end
            default: ;
        endcase
    end

    // Output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.wb == qbd_pkg::WB_OUT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.out_busy = r_ov;
    assign o_out_valid       = r_ov;
    assign o_value_bits      = r_val;
    assign o_element_index   = r_idx;
    assign o_block_last      = r_blast;
    assign o_run_last        = r_rlast;

endmodule

>>> sv/qbd_ctrl.sv
// Sequencer: steps the arithmetic unit through the operations of each word.
// Depends on qbd_pkg.
module qbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  qbd_pkg::t_status i_status,
    output qbd_pkg::t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DSC, S_DSC_WB, S_MMIN, S_MMIN_WB,
        S_PROD, S_PROD_WB, S_DIFF, S_DIFF_WB, S_SCALE, S_SCALE_WB
    } t_state;

    t_state r_state;
    logic   r_half;

    assign o_in_ready = (r_state == S_IDLE);

    // Commands for the current step
    always_comb begin
        o_cmd.accept = i_in_valid && (r_state == S_IDLE);
        o_cmd.half   = r_half;
        o_cmd.wb     = qbd_pkg::WB_NONE;
        o_cmd.opsel  = qbd_pkg::OP_DSC;
        unique case (r_state)
            S_MMIN:     o_cmd.opsel = qbd_pkg::OP_MMIN;
            S_PROD:     o_cmd.opsel = qbd_pkg::OP_PROD;
            S_DIFF:     o_cmd.opsel = qbd_pkg::OP_DIFF;
            S_SCALE:    o_cmd.opsel = (i_status.kind == qbd_pkg::K_Q5) ?
                                      qbd_pkg::OP_Q5 : qbd_pkg::OP_Q8;
            S_DSC_WB:   o_cmd.wb = qbd_pkg::WB_T1;
            S_MMIN_WB:  o_cmd.wb = qbd_pkg::WB_T2;
            S_PROD_WB:  o_cmd.wb = qbd_pkg::WB_T1;
            S_DIFF_WB:  o_cmd.wb = qbd_pkg::WB_OUT;
            S_SCALE_WB: o_cmd.wb = qbd_pkg::WB_OUT;
            default: ;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_half  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_half <= 1'b0;
                    case (i_status.kind)
                        qbd_pkg::K_Q4K: r_state <= S_DSC;
                        qbd_pkg::K_NONE: r_state <= S_IDLE;
                        default: r_state <= S_SCALE;
                    endcase
                end
                S_DSC:     r_state <= S_DSC_WB;
                S_DSC_WB:  r_state <= S_MMIN;
                S_MMIN:    r_state <= S_MMIN_WB;
                S_MMIN_WB: r_state <= S_PROD;
                S_PROD:    r_state <= S_PROD_WB;
                S_PROD_WB: r_state <= S_DIFF;
                S_DIFF: begin
                    if (!i_status.out_busy) r_state <= S_DIFF_WB;
                end
                S_DIFF_WB: begin
                    if (r_half) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_half  <= 1'b1;
                        r_state <= S_DSC;
                    end
                end
                S_SCALE: begin
                    if (!i_status.out_busy) r_state <= S_SCALE_WB;
                end
                S_SCALE_WB: begin
                    if (r_half || (i_status.kind == qbd_pkg::K_Q8)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_half  <= 1'b1;
                        r_state <= S_SCALE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/quantized_block_dequantizer.sv
// Words are taken one at a time: a new word is accepted only after the sequencer
// has finished the last one on the one shared two-step multiply/subtract unit
// (4 operations per Q4_K value, one per Q8_0 or Q5_0 value).
// A result word still waiting at the output stalls the sequencer until it is taken.
// Synchronous active-low reset clears format, position, header values, mask and the output valid flag, not the scales.
module quantized_block_dequantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packed_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value_bits,
    output logic [7:0]  o_element_index,
    output logic        o_block_last,
    output logic        o_run_last
);
    qbd_pkg::t_cmd    cmd;
    qbd_pkg::t_status status;

    qbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qbd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_packed_byte   (i_packed_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_value_bits    (o_value_bits),
        .o_element_index (o_element_index),
        .o_block_last    (o_block_last),
        .o_run_last      (o_run_last)
    );

endmodule

>>> sv/qbd_checker.sv
// Port-level checks of the dequantizer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module qbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_value_bits,
    input logic [7:0]  o_element_index
);
    // Hold a stalled result word
    `QBD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")
    `QBD_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_value_bits) && $stable(o_element_index), "result changed while stalled")
    // One word at a time: ready drops after an accept
    `QBD_ASSERT(a_one_word, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "second word taken while busy")
    // No result straight out of reset
    `QBD_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")
endmodule

bind quantized_block_dequantizer qbd_checker u_chk (.*);
